@@ hw/rtl/u8fc_pkg.sv @@
// shared types, constants and the pair glyph table for the utf-8 font code translator
package u8fc_pkg;

  localparam int unsigned BYTE_W = 8;

  // glyph given for a pair that is not in the table, or a lone lead byte
  localparam logic [BYTE_W-1:0] UNKNOWN_CODE = 8'h3F;

  // decoder verdict for one accepted request
  typedef struct packed {
    logic              emit;      // a result comes out of this request
    logic [BYTE_W-1:0] code;      // font code of that result
    logic              last;      // end-of-string mark of that result
    logic              pend_nxt;  // a lead byte is held after this request
  } u8fc_dec_t;

  // two-byte sequence to glyph index, unknown pairs give the question mark
  function automatic logic [BYTE_W-1:0] pair_glyph(input logic [BYTE_W-1:0] first,
                                                   input logic [BYTE_W-1:0] second);
    logic [BYTE_W-1:0] glyph;
    glyph = UNKNOWN_CODE;
    unique case ({first, second})
      16'hC5BE: glyph = 8'h98;
      16'hC5BD: glyph = 8'hA7;
      16'hC5AF: glyph = 8'h90;
      16'hC5AE: glyph = 8'h9F;
      16'hC5A5: glyph = 8'h96;
      16'hC5A4: glyph = 8'hA5;
      16'hC5A1: glyph = 8'h93;
      16'hC5A0: glyph = 8'hA2;
      16'hC599: glyph = 8'h92;
      16'hC598: glyph = 8'hA1;
      16'hC588: glyph = 8'h97;
      16'hC587: glyph = 8'hA6;
      16'hC5B8: glyph = 8'h84;
      16'hC49B: glyph = 8'h91;
      16'hC49A: glyph = 8'hA0;
      16'hC48F: glyph = 8'h95;
      16'hC48E: glyph = 8'hA4;
      16'hC48D: glyph = 8'h94;
      16'hC48C: glyph = 8'hA3;
      16'hC3BD: glyph = 8'h8D;
      16'hC3BA: glyph = 8'h8F;
      16'hC3B3: glyph = 8'h8E;
      16'hC3AD: glyph = 8'h8C;
      16'hC3A9: glyph = 8'h8B;
      16'hC3A1: glyph = 8'h8A;
      16'hC39D: glyph = 8'h9C;
      16'hC39A: glyph = 8'h9E;
      16'hC393: glyph = 8'h9D;
      16'hC38D: glyph = 8'h9B;
      16'hC389: glyph = 8'h9A;
      16'hC381: glyph = 8'h99;
      16'hC3BF: glyph = 8'h84;
      16'hC3BC: glyph = 8'h86;
      16'hC3B6: glyph = 8'h85;
      16'hC3AF: glyph = 8'h83;
      16'hC3AB: glyph = 8'h82;
      16'hC3A4: glyph = 8'h81;
      16'hC39C: glyph = 8'h89;
      16'hC396: glyph = 8'h88;
      16'hC38F: glyph = 8'h83;
      16'hC38B: glyph = 8'h82;
      16'hC384: glyph = 8'h87;
      default:  glyph = UNKNOWN_CODE;
    endcase
    return glyph;
  endfunction

endpackage

@@ hw/rtl/u8fc_ifs.sv @@
// valid/ready channel interfaces for the byte input and the font code output

interface u8fc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface u8fc_code_if;
  logic       valid;
  logic       ready;
  logic [7:0] font_code;
  logic       out_last;

  modport source (output valid, output font_code, output out_last, input ready);
  modport sink   (input valid, input font_code, input out_last, output ready);
endinterface

@@ hw/rtl/u8fc_decode.sv @@
// combinational decode of one byte against the held lead byte
module u8fc_decode
  import u8fc_pkg::*;
(
  input  logic [BYTE_W-1:0] byte_i,
  input  logic              last_i,
  input  logic              pend_i,
  input  logic [BYTE_W-1:0] lead_i,
  output u8fc_dec_t         dec_o
);

  always_comb begin
    dec_o.last     = last_i;
    dec_o.pend_nxt = 1'b0;
    dec_o.emit     = 1'b1;
    dec_o.code     = byte_i;
    if (pend_i) begin
      // second byte of a pair, whatever its value
      dec_o.code = pair_glyph(lead_i, byte_i);
    end else if (byte_i[BYTE_W-1]) begin
      if (last_i) begin
        // lead byte with nothing to pair with
        dec_o.code = UNKNOWN_CODE;
      end else begin
        dec_o.emit     = 1'b0;
        dec_o.pend_nxt = 1'b1;
      end
    end
  end

endmodule

@@ hw/rtl/utf8_pair_to_font_code_unit.sv @@
// top level: utf-8 two-byte pair to font code translator
// a result is registered and appears in the cycle after the request that completes it
// throughput: one byte request per cycle while the receiver takes results; a lead byte gives no result
// the single output register frees in the same cycle it is taken, so input
// ready follows output ready combinationally
// reset (synchronous, rst_n low) drops the held lead byte and the output valid
module utf8_pair_to_font_code_unit
  import u8fc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  u8fc_byte_if.sink   in_chan,
  u8fc_code_if.source out_chan
);

  // lead byte hold
  logic              pend_r,  pend_nxt;
  logic [BYTE_W-1:0] lead_r,  lead_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] code_r,      code_nxt;
  logic              last_r,      last_nxt;

  logic      in_ready;
  logic      in_take;
  u8fc_dec_t dec;

  // output slot is free when empty or being drained this cycle
  assign in_ready = !out_valid_r || out_chan.ready;
  assign in_take  = in_chan.valid && in_ready;

  u8fc_decode u_decode (
    .byte_i (in_chan.in_byte),
    .last_i (in_chan.in_last),
    .pend_i (pend_r),
    .lead_i (lead_r),
    .dec_o  (dec)
  );

  always_comb begin
    pend_nxt      = pend_r;
    lead_nxt      = lead_r;
    out_valid_nxt = out_valid_r;
    code_nxt      = code_r;
    last_nxt      = last_r;
    if (in_ready) begin
      // slot drains or stays empty unless a new result lands
      out_valid_nxt = in_take && dec.emit;
    end
    if (in_take) begin
      pend_nxt = dec.pend_nxt;
      code_nxt = dec.code;
      last_nxt = dec.last;
      if (dec.pend_nxt) begin
        lead_nxt = in_chan.in_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      lead_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      lead_r      <= lead_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    code_r <= code_nxt;
    last_r <= last_nxt;
  end

  assign in_chan.ready      = in_ready;
  assign out_chan.valid     = out_valid_r;
  assign out_chan.font_code = code_r;
  assign out_chan.out_last  = last_r;

endmodule

@@ hw/rtl/u8fc_checker.sv @@
// port-level assertions for the translator, bound to the top level
module u8fc_checker
  import u8fc_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic [BYTE_W-1:0] in_byte,
  input logic              in_last,
  input logic              out_valid,
  input logic              out_ready,
  input logic [BYTE_W-1:0] font_code,
  input logic              out_last
);

  logic in_take;
  logic pend_r, pend_nxt;

  assign in_take = in_valid && in_ready;

  // shadow of the lead byte hold, rebuilt from the ports
  always_comb begin
    pend_nxt = pend_r;
    if (in_take) begin
      pend_nxt = !pend_r && in_byte[BYTE_W-1] && !in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(font_code) && $stable(out_last))
    else $error("stalled result changed");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_ascii_pass: assert property (@(posedge clk) disable iff (!rst_n)
    in_take && !pend_r && !in_byte[BYTE_W-1]
      |=> out_valid && font_code == $past(in_byte) && out_last == $past(in_last))
    else $error("plain byte not passed through");

  a_lead_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_take && !pend_r && in_byte[BYTE_W-1] && !in_last |=> !out_valid)
    else $error("lead byte produced a result");

endmodule

bind utf8_pair_to_font_code_unit u8fc_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .in_byte   (in_chan.in_byte),
  .in_last   (in_chan.in_last),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .font_code (out_chan.font_code),
  .out_last  (out_chan.out_last)
);

@@ test/utf8_pair_to_font_code_unit_test.sv @@
// self-checking testbench for the utf-8 pair to font code translator
`timescale 1ns / 100ps

module utf8_pair_to_font_code_unit_test;
  import u8fc_pkg::*;

  localparam int unsigned PAIR_COUNT = 42;
  localparam logic [7:0]  LEAD_MIN   = 8'h80;
  localparam int unsigned TEXT_ITEMS = 1800;
  localparam int unsigned HOLD_LEN   = 200;
  localparam int unsigned DRAIN_MAX  = 20000;

  // lead byte, trail byte, glyph index; first match wins
  localparam logic [PAIR_COUNT*24-1:0] CZ_DE_PAIRS = {
    24'hC5BE98, 24'hC5BDA7, 24'hC5AF90, 24'hC5AE9F, 24'hC5A596, 24'hC5A4A5,
    24'hC5A193, 24'hC5A0A2, 24'hC59992, 24'hC598A1, 24'hC58897, 24'hC587A6,
    24'hC5B884,
    24'hC49B91, 24'hC49AA0, 24'hC48F95, 24'hC48EA4, 24'hC48D94, 24'hC48CA3,
    24'hC3BD8D, 24'hC3BA8F, 24'hC3B38E, 24'hC3AD8C, 24'hC3A98B, 24'hC3A18A,
    24'hC39D9C, 24'hC39A9E, 24'hC3939D, 24'hC38D9B, 24'hC3899A, 24'hC38199,
    24'hC3BF84, 24'hC3BC86, 24'hC3B685, 24'hC3AF83, 24'hC3AB82, 24'hC3A481,
    24'hC39C89, 24'hC39688, 24'hC38F83, 24'hC38B82, 24'hC38487
  };

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } font_result_t;

  logic clk = 1'b0;
  logic rst_n;

  u8fc_byte_if in_if ();
  u8fc_code_if out_if ();

  utf8_pair_to_font_code_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  // 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // translator state as seen from outside
  logic         lead_held;
  logic [7:0]   lead_val;
  font_result_t expected_codes[$];
  font_result_t want;

  int unsigned error_count  = 0;
  int unsigned items_sent   = 0;
  bit          pacing_on    = 1'b0;
  int unsigned burst_left   = 0;
  int unsigned hold_request = 0;

  // table entry k, counted from the start of the list
  function automatic logic [23:0] pair_entry(input int unsigned k);
    return CZ_DE_PAIRS[(PAIR_COUNT-1-k)*24 +: 24];
  endfunction

  function automatic logic [7:0] glyph_for_pair(input logic [7:0] first,
                                                input logic [7:0] second);
    logic [23:0] entry;
    for (int unsigned k = 0; k < PAIR_COUNT; k++) begin
      entry = pair_entry(k);
      if (entry[23:16] == first && entry[15:8] == second) return entry[7:0];
    end
    return UNKNOWN_CODE;
  endfunction

  // work out what one accepted byte request gives, and move the held lead on
  task automatic decode_text_byte(input logic [7:0] b, input logic last);
    if (lead_held) begin
      // any byte closes the pair, ascii ones included
      expected_codes.push_back('{code: glyph_for_pair(lead_val, b), last: last});
      lead_held = 1'b0;
    end else if (b < LEAD_MIN) begin
      expected_codes.push_back('{code: b, last: last});
    end else if (last) begin
      // lead byte at the end of the string has nothing to pair with
      expected_codes.push_back('{code: UNKNOWN_CODE, last: 1'b1});
    end else begin
      lead_val  = b;
      lead_held = 1'b1;
    end
  endtask

  // sender pause with the payload scrambled, valid low
  task automatic sender_gap(input int unsigned cycles);
    in_if.valid   <= 1'b0;
    in_if.in_byte <= 8'($urandom);
    in_if.in_last <= 1'($urandom);
    repeat (cycles) @(negedge clk);
  endtask

  // bursts of random length, gaps of random length (sometimes none)
  task automatic pace_sender();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      if ($urandom_range(0, 3) != 0) sender_gap($urandom_range(1, 6));
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                : $urandom_range(0, 16);
    end
  endtask

  // offer one byte request from a falling edge; returns at the falling edge
  // after it was taken, with valid still high
  task automatic push_byte(input logic [7:0] b, input logic last);
    in_if.valid   <= 1'b1;
    in_if.in_byte <= b;
    in_if.in_last <= last;
    forever begin
      @(posedge clk);
      if (in_if.ready) break;
    end
    decode_text_byte(b, last);
    items_sent++;
    @(negedge clk);
    if (pacing_on) pace_sender();
  endtask

  task automatic push_table_pair(input int unsigned k, input logic last);
    logic [23:0] entry;
    entry = pair_entry(k);
    push_byte(entry[23:16], 1'b0);
    push_byte(entry[15:8], last);
  endtask

  // one string of random characters: mostly ascii and table pairs, some
  // broken pairs and stray lead bytes; the final byte carries the last mark
  task automatic send_text(input int unsigned chars);
    int unsigned pick;
    logic        at_end;
    for (int unsigned i = 0; i < chars; i++) begin
      at_end = (i == chars - 1);
      pick   = $urandom_range(0, 99);
      if (pick < 50) begin
        push_byte(8'($urandom_range(0, 127)), at_end);
      end else if (pick < 85) begin
        push_table_pair($urandom_range(0, PAIR_COUNT - 1), at_end);
      end else if (pick < 92) begin
        push_byte(8'($urandom_range(128, 255)), 1'b0);
        push_byte(8'($urandom_range(0, 255)), at_end);
      end else begin
        // stray lead: pairs with whatever follows, or stands alone at the end
        push_byte(8'($urandom_range(128, 255)), at_end);
      end
    end
  endtask

  // receiver: long hold-off on request, otherwise a stall density that
  // changes from phase to phase, zero included
  always @(negedge clk) begin : receiver_stalls
    static int unsigned hold_left  = 0;
    static int unsigned phase_left = 0;
    static int unsigned stall_pct  = 0;
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      if (phase_left == 0) begin
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 20;
          2: stall_pct = 50;
          default: stall_pct = 85;
        endcase
        phase_left = $urandom_range(16, 96);
      end
      phase_left--;
      out_if.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // every taken result is matched against the oldest expectation
  always @(posedge clk) begin : result_check
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_codes.size() == 0) begin
        $error("unexpected result: font_code %02h out_last %0b",
               out_if.font_code, out_if.out_last);
        error_count++;
      end else begin
        want = expected_codes.pop_front();
        if (out_if.font_code !== want.code) begin
          $error("font_code: expected %02h, actual %02h", want.code, out_if.font_code);
          error_count++;
        end
        if (out_if.out_last !== want.last) begin
          $error("out_last: expected %0b, actual %0b", want.last, out_if.out_last);
          error_count++;
        end
      end
    end
  end

  // ascii passes through unchanged, zero included
  task automatic test_ascii_passthrough();
    push_byte(8'h00, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_byte(8'h41, 1'b1);
  endtask

  // known pairs: the first and last entries of the list, the last one ending a string, and entry 12
  task automatic test_table_pairs();
    push_table_pair(0, 1'b0);
    push_table_pair(PAIR_COUNT - 1, 1'b1);
    push_table_pair(12, 1'b0);
  endtask

  // lone leads at the end of a string, pairs closed by ascii or by a second
  // lead, and pairs not in the table
  task automatic test_broken_pairs();
    push_byte(8'hFF, 1'b1);
    push_byte(8'h80, 1'b1);
    push_byte(8'hC5, 1'b0);
    push_byte(8'h41, 1'b0);
    push_byte(8'hC5, 1'b0);
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hC3, 1'b0);
    push_byte(8'hC3, 1'b1);
    push_byte(8'h80, 1'b0);
    push_byte(8'h80, 1'b0);
  endtask

  // receiver holds off for a long stretch while requests keep coming, so
  // the output register fills and input ready drops
  task automatic test_back_pressure();
    hold_request = HOLD_LEN;
    pacing_on    = 1'b0;
    repeat (6) send_text($urandom_range(4, 10));
  endtask

  task automatic test_random_text();
    int unsigned start;
    start     = items_sent;
    pacing_on = 1'b1;
    while (items_sent - start < TEXT_ITEMS) send_text($urandom_range(1, 24));
    pacing_on = 1'b0;
  endtask

  initial begin : stimulus
    int unsigned waited;
    rst_n         = 1'b0;
    in_if.valid   = 1'b0;
    in_if.in_byte = 8'h00;
    in_if.in_last = 1'b0;
    out_if.ready  = 1'b0;
    lead_held     = 1'b0;
    lead_val      = 8'h00;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_ascii_passthrough();
    test_table_pairs();
    test_broken_pairs();
    test_back_pressure();
    test_random_text();
    sender_gap(1);

    // drain: wait until every expected result has been taken
    waited = 0;
    while (expected_codes.size() != 0 && waited < DRAIN_MAX) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
    if (expected_codes.size() != 0) begin
      $error("%0d expected results never arrived", expected_codes.size());
      error_count++;
    end

    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin : watchdog
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

@@ utf8_pair_to_font_code_unit.f @@
hw/rtl/u8fc_pkg.sv
hw/rtl/u8fc_ifs.sv
hw/rtl/u8fc_decode.sv
hw/rtl/utf8_pair_to_font_code_unit.sv
hw/rtl/u8fc_checker.sv
test/utf8_pair_to_font_code_unit_test.sv
